FILE: src/khs_pkg.sv
// Shared types and constants for the key request handshake block.
package khs_pkg;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_ECHO = 5'b00010,
    PH_CMD  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_MOD  = 5'b10000
  } phase_t;

  localparam logic [1:0] REQ_TRIGGER = 2'd0;
  localparam logic [1:0] REQ_BYTE    = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;

  localparam logic [2:0] LED_NONE   = 3'd0;
  localparam logic [2:0] LED_BUSY   = 3'd1;
  localparam logic [2:0] LED_FAILED = 3'd2;
  localparam logic [2:0] LED_NORESP = 3'd3;
  localparam logic [2:0] LED_DONE   = 3'd4;

  localparam logic [7:0] BYTE_HELLO   = 8'h01;
  localparam logic [7:0] BYTE_COMMAND = 8'h02;
  localparam logic [7:0] BYTE_KEY_OK  = 8'h03;
  localparam logic [7:0] BYTE_MOD_OK  = 8'h04;

  localparam logic [3:0] KEY_BYTES = 4'h8;
  localparam logic [3:0] MOD_BYTES = 4'h4;

  localparam logic [1:0] CFG_INITIAL_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_TOTAL_TIMEOUT   = 2'd1;

  localparam logic [23:0] INITIAL_TIMEOUT_RST = 24'd1000000;
  localparam logic [23:0] TOTAL_TIMEOUT_RST   = 24'd5000000;
  localparam logic [23:0] ELAPSED_MAX         = 24'hFFFFFF;

  typedef struct packed {
    phase_t      phase;
    logic [23:0] elapsed_us;
    logic [3:0]  bytes_in_block;
    logic [63:0] assembly_shift;
    logic [63:0] committed_key;
    logic [31:0] committed_modulus;
    logic [2:0]  status_shown;
  } state_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [2:0]  led_status;
    logic [63:0] key_value;
    logic [31:0] modulus_value;
    logic        in_progress;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:             PH_IDLE,
    elapsed_us:        24'd0,
    bytes_in_block:    4'd0,
    assembly_shift:    64'd0,
    committed_key:     64'd0,
    committed_modulus: 32'd0,
    status_shown:      LED_NONE
  };

endpackage

FILE: src/key_request_handshake_top.sv
// Top level of the key request handshake block.
//
// Requests arrive on the in_ channel (in_valid/in_stall) with a type and a
// received byte: a trigger edge, a received serial byte or a one microsecond
// tick. Every request yields exactly one result on the out_ channel
// (out_valid/out_stall): an optional byte to transmit, the LED status, the
// committed key and modulus and the in-progress flag.
// The cfg_ port writes the two timeout registers (index 0 initial, 1 total);
// it is always ready, and writes are meant to happen while the block is idle.
//
// A request is taken into an input register, evaluated in one pass of the
// step logic and written into the output register. One request can be
// accepted every cycle while out_stall is low. When out_stall holds a
// result, the input register still takes one more request; after that
// in_stall rises until the result is taken. Synchronous reset clears both
// stages, the handshake state and the committed values, and loads the
// default timeouts.
module key_request_handshake_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic [2:0]  out_led_status,
  output logic [63:0] out_key_value,
  output logic [31:0] out_modulus_value,
  output logic        out_in_progress,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [23:0] init_to_r;
  logic [23:0] total_to_r;

  logic        s1_valid_r;
  logic [1:0]  s1_type_r;
  logic [7:0]  s1_byte_r;

  logic             out_valid_r;
  khs_pkg::result_t out_res_r;

  khs_pkg::state_t  st_r;
  khs_pkg::state_t  st_nxt;
  khs_pkg::result_t res_nxt;

  logic advance;
  logic in_take;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_to_r  <= khs_pkg::INITIAL_TIMEOUT_RST;
      total_to_r <= khs_pkg::TOTAL_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        khs_pkg::CFG_INITIAL_TIMEOUT: init_to_r  <= cfg_data;
        khs_pkg::CFG_TOTAL_TIMEOUT:   total_to_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_type_r <= in_req_type;
      s1_byte_r <= in_rx_byte;
    end
  end

  khs_step u_step (
    .cur                (st_r),
    .req_type           (s1_type_r),
    .rx_byte            (s1_byte_r),
    .initial_timeout_us (init_to_r),
    .total_timeout_us   (total_to_r),
    .nxt                (st_nxt),
    .res                (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= khs_pkg::STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tx_valid      = out_res_r.tx_valid;
  assign out_tx_byte       = out_res_r.tx_byte;
  assign out_led_status    = out_res_r.led_status;
  assign out_key_value     = out_res_r.key_value;
  assign out_modulus_value = out_res_r.modulus_value;
  assign out_in_progress   = out_res_r.in_progress;

`ifndef SYNTHESIS
  // An idle handshake holds no partial block.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == khs_pkg::PH_IDLE) |->
      (st_r.bytes_in_block == 4'd0 && st_r.assembly_shift == 64'd0))
    else $error("idle phase with partial block");

  // The key byte count never reaches a full key without a commit.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bytes_in_block < khs_pkg::KEY_BYTES)
    else $error("byte count out of range");

  // The committed key changes only when the key block completes.
  a_key_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(st_r.committed_key)) |->
      ($past(st_r.phase) == khs_pkg::PH_KEY && st_r.phase == khs_pkg::PH_MOD))
    else $error("key changed outside key block");

  // A new run starts with the elapsed time cleared.
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(st_r.phase) == khs_pkg::PH_IDLE &&
     st_r.phase == khs_pkg::PH_ECHO) |-> (st_r.elapsed_us == 24'd0))
    else $error("run started with stale elapsed time");

  // A state update always produces a result in the output register.
  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("state advanced without a result");
`endif

endmodule

FILE: src/khs_step.sv
// Next-state and result logic for one request of the key request handshake.
module khs_step (
  input  khs_pkg::state_t  cur,
  input  logic [1:0]       req_type,
  input  logic [7:0]       rx_byte,
  input  logic [23:0]      initial_timeout_us,
  input  logic [23:0]      total_timeout_us,
  output khs_pkg::state_t  nxt,
  output khs_pkg::result_t res
);

  logic [7:0]  send;
  logic [23:0] elapsed_inc;
  logic [63:0] shift_new;
  logic [3:0]  count_new;

  assign elapsed_inc = (cur.elapsed_us == khs_pkg::ELAPSED_MAX) ?
                       cur.elapsed_us : cur.elapsed_us + 24'd1;
  assign shift_new   = {cur.assembly_shift[55:0], rx_byte};
  assign count_new   = cur.bytes_in_block + 4'd1;

  always_comb begin
    nxt  = cur;
    send = 8'd0;
    case (req_type)
      khs_pkg::REQ_TRIGGER: begin
        if (cur.phase == khs_pkg::PH_IDLE) begin
          nxt.phase          = khs_pkg::PH_ECHO;
          nxt.elapsed_us     = 24'd0;
          nxt.bytes_in_block = 4'd0;
          nxt.assembly_shift = 64'd0;
          nxt.status_shown   = khs_pkg::LED_BUSY;
          send               = khs_pkg::BYTE_HELLO;
        end
      end
      khs_pkg::REQ_BYTE: begin
        unique case (cur.phase)
          khs_pkg::PH_ECHO: begin
            if (rx_byte == khs_pkg::BYTE_HELLO) begin
              nxt.phase = khs_pkg::PH_CMD;
            end else begin
              nxt.phase          = khs_pkg::PH_IDLE;
              nxt.status_shown   = khs_pkg::LED_FAILED;
              nxt.bytes_in_block = 4'd0;
              nxt.assembly_shift = 64'd0;
            end
          end
          khs_pkg::PH_CMD: begin
            nxt.bytes_in_block = 4'd0;
            nxt.assembly_shift = 64'd0;
            if (rx_byte == khs_pkg::BYTE_COMMAND) begin
              nxt.phase = khs_pkg::PH_KEY;
              send      = khs_pkg::BYTE_COMMAND;
            end else begin
              nxt.phase        = khs_pkg::PH_IDLE;
              nxt.status_shown = khs_pkg::LED_FAILED;
            end
          end
          khs_pkg::PH_KEY: begin
            if (count_new >= khs_pkg::KEY_BYTES) begin
              nxt.committed_key  = shift_new;
              nxt.phase          = khs_pkg::PH_MOD;
              nxt.bytes_in_block = 4'd0;
              nxt.assembly_shift = 64'd0;
              send               = khs_pkg::BYTE_KEY_OK;
            end else begin
              nxt.bytes_in_block = count_new;
              nxt.assembly_shift = shift_new;
            end
          end
          khs_pkg::PH_MOD: begin
            if (count_new >= khs_pkg::MOD_BYTES) begin
              nxt.committed_modulus = shift_new[31:0];
              nxt.phase             = khs_pkg::PH_IDLE;
              nxt.status_shown      = khs_pkg::LED_DONE;
              nxt.bytes_in_block    = 4'd0;
              nxt.assembly_shift    = 64'd0;
              send                  = khs_pkg::BYTE_MOD_OK;
            end else begin
              nxt.bytes_in_block = count_new;
              nxt.assembly_shift = shift_new;
            end
          end
          default: ;
        endcase
      end
      khs_pkg::REQ_TICK: begin
        if (cur.phase != khs_pkg::PH_IDLE) begin
          nxt.elapsed_us = elapsed_inc;
          if (cur.phase == khs_pkg::PH_ECHO) begin
            if (elapsed_inc > initial_timeout_us) begin
              nxt.phase          = khs_pkg::PH_IDLE;
              nxt.status_shown   = khs_pkg::LED_NORESP;
              nxt.bytes_in_block = 4'd0;
              nxt.assembly_shift = 64'd0;
            end
          end else if (cur.phase == khs_pkg::PH_CMD || cur.bytes_in_block == 4'd0) begin
            // Once a block has its first byte, time keeps counting but cannot expire.
            if (elapsed_inc > total_timeout_us) begin
              nxt.phase          = khs_pkg::PH_IDLE;
              nxt.status_shown   = khs_pkg::LED_FAILED;
              nxt.bytes_in_block = 4'd0;
              nxt.assembly_shift = 64'd0;
            end
          end
        end
      end
      default: ;
    endcase

    res.tx_valid      = (send != 8'd0);
    res.tx_byte       = send;
    res.led_status    = nxt.status_shown;
    res.key_value     = nxt.committed_key;
    res.modulus_value = nxt.committed_modulus;
    res.in_progress   = (nxt.phase != khs_pkg::PH_IDLE);
  end

endmodule
